### rtl/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
// No dependencies; imported by the result interface, the solver unit and the checker.
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ROOT_W         = 40;

   typedef enum logic [1:0] {
      KIND_REAL    = 2'd0,
      KIND_COMPLEX = 2'd1,
      KIND_LINEAR  = 2'd2,
      KIND_NONE    = 2'd3
   } root_kind_type;

endpackage

### rtl/qrs_req_if.sv
// Coefficient channel: valid/ready handshake with a, b and c.
// Depends on nothing but its width parameter.
interface qrs_req_if #(parameter int CW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] coef_square;
   logic signed [CW-1:0] coef_linear;
   logic signed [CW-1:0] coef_const;

   modport source (output valid, coef_square, coef_linear, coef_const, input ready);
   modport sink   (input valid, coef_square, coef_linear, coef_const, output ready);
endinterface

### rtl/qrs_rsp_if.sv
// Root channel: valid/ready handshake with the kind and four Q.F parts.
// Depends on qrs_pkg for the root width and the kind type.
interface qrs_rsp_if import qrs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   root_kind_type            root_kind;
   logic signed [ROOT_W-1:0] first_real;
   logic signed [ROOT_W-1:0] first_imag;
   logic signed [ROOT_W-1:0] second_real;
   logic signed [ROOT_W-1:0] second_imag;

   modport source (output valid, root_kind, first_real, first_imag, second_real,
                   second_imag, input ready);
   modport sink   (input valid, root_kind, first_real, first_imag, second_real,
                   second_imag, output ready);
   modport monitor (input valid, ready, root_kind, first_real, first_imag,
                    second_real, second_imag);
endinterface

### rtl/quadratic_root_solver_unit.sv
// Quadratic root solver: one coefficient set per cycle, one result per set.
// Stages: stage 0 to stage 2, SW square-root stages, NDW divider stages
// and the output register.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output register is full and not taken. Synchronous reset clears all valid
// bits; data registers are not reset.
module quadratic_root_solver_unit import qrs_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   qrs_req_if.sink       req_chan,
   qrs_rsp_if.source     rsp_chan
);
   localparam int CW    = COEF_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int PW    = 2 * CW;
   localparam int DMW   = PW + 3;
   localparam int RW0   = DMW + 2 * F;
   localparam int RW    = RW0 + (RW0 % 2);
   localparam int SW    = RW / 2;
   localparam int NDW   = (CW + F > SW) ? CW + F : SW;
   localparam int DVW   = CW + 1;
   localparam int EW0   = NDW + F + 2;
   localparam int EW    = ((EW0 > ROOT_W) ? EW0 : ROOT_W) + 1;
   localparam int SQS_W = 4 + DVW + NDW;

   logic en;
   logic out_v_ff;

   // the pipeline advances whenever the output register can move
   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---- stage 0: register magnitudes and signs ----
   logic [CW-1:0] ra, rb, rc;
   logic          v0_ff, na0_ff, nb0_ff, nc0_ff;
   logic [CW-1:0] ma0_ff, mb0_ff, mc0_ff;

   assign ra = req_chan.coef_square;
   assign rb = req_chan.coef_linear;
   assign rc = req_chan.coef_const;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_chan.valid;
      end
      if (en) begin
         na0_ff <= ra[CW-1];
         nb0_ff <= rb[CW-1];
         nc0_ff <= rc[CW-1];
         ma0_ff <= ra[CW-1] ? -ra : ra;
         mb0_ff <= rb[CW-1] ? -rb : rb;
         mc0_ff <= rc[CW-1] ? -rc : rc;
      end
   end

   // ---- stage 1: products and division operands ----
   logic            v1_ff, na1_ff, psign1_ff, addm1_ff, az1_ff, bz1_ff;
   logic [PW-1:0]   bb1_ff, ac1_ff;
   logic [DVW-1:0]  den1_ff;
   logic [NDW-1:0]  pnum1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         bb1_ff <= PW'(mb0_ff) * PW'(mb0_ff);
         ac1_ff <= PW'(ma0_ff) * PW'(mc0_ff);
         na1_ff <= na0_ff;
         az1_ff <= (ma0_ff == '0);
         bz1_ff <= (mb0_ff == '0);
         addm1_ff <= (mc0_ff != '0) && (na0_ff != nc0_ff);
         if (ma0_ff == '0) begin
            // linear root: c / b
            den1_ff   <= DVW'(mb0_ff);
            pnum1_ff  <= NDW'(mc0_ff);
            psign1_ff <= (mc0_ff != '0) && (nc0_ff == nb0_ff);
         end else begin
            den1_ff   <= {ma0_ff, 1'b0};
            pnum1_ff  <= NDW'({mb0_ff, {F{1'b0}}});
            psign1_ff <= (mb0_ff != '0) && (nb0_ff == na0_ff);
         end
      end
   end

   // ---- stage 2: determinant magnitude and sign, root kind ----
   logic [DMW-1:0]  bbw, facw;
   logic            v2_ff, na2_ff, psign2_ff;
   logic [DMW-1:0]  dmag2_ff;
   root_kind_type   kind2_ff;
   logic [DVW-1:0]  den2_ff;
   logic [NDW-1:0]  pnum2_ff;

   assign bbw  = DMW'(bb1_ff);
   assign facw = DMW'({ac1_ff, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         na2_ff    <= na1_ff;
         psign2_ff <= psign1_ff;
         den2_ff   <= den1_ff;
         pnum2_ff  <= pnum1_ff;
         if (addm1_ff) begin
            dmag2_ff <= bbw + facw;
         end else if (bbw >= facw) begin
            dmag2_ff <= bbw - facw;
         end else begin
            dmag2_ff <= facw - bbw;
         end
         if (!az1_ff) begin
            kind2_ff <= (!addm1_ff && bbw < facw) ? KIND_COMPLEX : KIND_REAL;
         end else if (!bz1_ff) begin
            kind2_ff <= KIND_LINEAR;
         end else begin
            kind2_ff <= KIND_NONE;
         end
      end
   end

   // ---- square root of |d| scaled by 2^(2F) ----
   logic [RW-1:0]    rad;
   logic [SQS_W-1:0] sq_side_in, sq_side_out;
   logic             sq_v;
   logic [SW-1:0]    sq_root;

   assign rad        = RW'({dmag2_ff, {(2 * F){1'b0}}});
   assign sq_side_in = {kind2_ff, psign2_ff, na2_ff, den2_ff, pnum2_ff};

   qrs_isqrt #(.RAD_W(RW), .SIDE_W(SQS_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .rad       (rad),
      .side_in   (sq_side_in),
      .out_valid (sq_v),
      .root      (sq_root),
      .side_out  (sq_side_out)
   );

   // ---- both quotients against the shared divisor ----
   logic [NDW-1:0] dv_pnum;
   logic [DVW-1:0] dv_den;
   logic [3:0]     dv_side_in, dv_side_out;
   logic           dv_v;
   logic [NDW-1:0] quot_p, quot_q;

   assign dv_pnum    = sq_side_out[NDW-1:0];
   assign dv_den     = sq_side_out[NDW +: DVW];
   assign dv_side_in = sq_side_out[SQS_W-1 -: 4];

   qrs_div #(.NUM_W(NDW), .DEN_W(DVW), .SIDE_W(4)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .num_p     (dv_pnum),
      .num_q     (NDW'(sq_root)),
      .den       (dv_den),
      .side_in   (dv_side_in),
      .out_valid (dv_v),
      .quot_p    (quot_p),
      .quot_q    (quot_q),
      .side_out  (dv_side_out)
   );

   // ---- combine signs, saturate and register the result ----
   localparam logic signed [EW-1:0] SAT_MAX =
      {{(EW - ROOT_W + 1){1'b0}}, {(ROOT_W - 1){1'b1}}};
   localparam logic signed [EW-1:0] SAT_MIN = ~SAT_MAX;

   function automatic logic [ROOT_W-1:0] sat(input logic signed [EW-1:0] v);
      logic [ROOT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[ROOT_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[ROOT_W-1:0];
      end else begin
         r = v[ROOT_W-1:0];
      end
      return r;
   endfunction

   root_kind_type          kind_f;
   logic                   psign_f, na_f;
   logic signed [EW-1:0]   pw, qw, lw;
   logic signed [EW-1:0]   r1, i1, r2, i2;

   assign kind_f  = root_kind_type'(dv_side_out[3:2]);
   assign psign_f = dv_side_out[1];
   assign na_f    = dv_side_out[0];
   assign pw = psign_f ? -$signed(EW'(quot_p)) : $signed(EW'(quot_p));
   assign qw = na_f ? -$signed(EW'(quot_q)) : $signed(EW'(quot_q));
   assign lw = psign_f ? -$signed(EW'(quot_p) << F) : $signed(EW'(quot_p) << F);

   always_comb begin
      r1 = '0;
      i1 = '0;
      r2 = '0;
      i2 = '0;
      case (kind_f)
         KIND_REAL: begin
            r1 = pw + qw;
            r2 = pw - qw;
         end
         KIND_COMPLEX: begin
            r1 = pw;
            r2 = pw;
            i1 = qw;
            i2 = -qw;
         end
         KIND_LINEAR: begin
            r1 = lw;
         end
         default: begin
            r1 = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_v;
      end
      if (en) begin
         rsp_chan.root_kind   <= kind_f;
         rsp_chan.first_real  <= sat(r1);
         rsp_chan.first_imag  <= sat(i1);
         rsp_chan.second_real <= sat(r2);
         rsp_chan.second_imag <= sat(i2);
      end
   end

   assign rsp_chan.valid = out_v_ff;
endmodule

### rtl/qrs_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Stand-alone; carries an opaque sideband alongside the radicand.
module qrs_isqrt #(
   parameter int RAD_W  = 68,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    rad,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [RAD_W/2-1:0]  root,
   output logic [SIDE_W-1:0]   side_out
);
   localparam int SW = RAD_W / 2;

   logic [SW-1:0]     v_ff;
   logic [RAD_W-1:0]  rad_ff  [SW];
   logic [SW+1:0]     rem_ff  [SW];
   logic [SW-1:0]     root_ff [SW];
   logic [SIDE_W-1:0] side_ff [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic              vin;
      logic [RAD_W-1:0]  rin;
      logic [SW+1:0]     remin;
      logic [SW-1:0]     rootin;
      logic [SIDE_W-1:0] sin;
      logic [SW+1:0]     rem_try;
      logic [SW+1:0]     trial;

      if (k == 0) begin : g_first
         assign vin    = in_valid;
         assign rin    = rad;
         assign remin  = '0;
         assign rootin = '0;
         assign sin    = side_in;
      end else begin : g_next
         assign vin    = v_ff[k-1];
         assign rin    = rad_ff[k-1];
         assign remin  = rem_ff[k-1];
         assign rootin = root_ff[k-1];
         assign sin    = side_ff[k-1];
      end

      // bring down the next two radicand bits and try the next root bit
      assign rem_try = {remin[SW-1:0], rin[RAD_W-1 -: 2]};
      assign trial   = {rootin, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vin;
         end
         if (en) begin
            rad_ff[k]  <= {rin[RAD_W-3:0], 2'b00};
            side_ff[k] <= sin;
            if (rem_try >= trial) begin
               rem_ff[k]  <= rem_try - trial;
               root_ff[k] <= {rootin[SW-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_try;
               root_ff[k] <= {rootin[SW-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign root      = root_ff[SW-1];
   assign side_out  = side_ff[SW-1];
endmodule

### rtl/qrs_div.sv
// Pipelined dual restoring divider, one quotient bit per register stage.
// Two numerators share one divisor; stand-alone, with an opaque sideband.
module qrs_div #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num_p,
   input  logic [NUM_W-1:0]  num_q,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quot_p,
   output logic [NUM_W-1:0]  quot_q,
   output logic [SIDE_W-1:0] side_out
);
   logic [NUM_W-1:0]  v_ff;
   logic [NUM_W-1:0]  np_ff   [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W:0]    rp_ff   [NUM_W];
   logic [DEN_W:0]    rq_ff   [NUM_W];
   logic [NUM_W-1:0]  qp_ff   [NUM_W];
   logic [NUM_W-1:0]  qq_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              vin;
      logic [NUM_W-1:0]  npin, nqin, qpin, qqin;
      logic [DEN_W:0]    rpin, rqin;
      logic [DEN_W-1:0]  dn;
      logic [SIDE_W-1:0] sin;
      logic [DEN_W:0]    rp_try, rq_try;

      if (k == 0) begin : g_first
         assign vin  = in_valid;
         assign npin = num_p;
         assign nqin = num_q;
         assign rpin = '0;
         assign rqin = '0;
         assign qpin = '0;
         assign qqin = '0;
         assign dn   = den;
         assign sin  = side_in;
      end else begin : g_next
         assign vin  = v_ff[k-1];
         assign npin = np_ff[k-1];
         assign nqin = nq_ff[k-1];
         assign rpin = rp_ff[k-1];
         assign rqin = rq_ff[k-1];
         assign qpin = qp_ff[k-1];
         assign qqin = qq_ff[k-1];
         assign dn   = den_ff[k-1];
         assign sin  = side_ff[k-1];
      end

      // bring down the next numerator bit of each division
      assign rp_try = {rpin[DEN_W-1:0], npin[NUM_W-1]};
      assign rq_try = {rqin[DEN_W-1:0], nqin[NUM_W-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vin;
         end
         if (en) begin
            np_ff[k]   <= npin << 1;
            nq_ff[k]   <= nqin << 1;
            den_ff[k]  <= dn;
            side_ff[k] <= sin;
            if (rp_try >= {1'b0, dn}) begin
               rp_ff[k] <= rp_try - {1'b0, dn};
               qp_ff[k] <= {qpin[NUM_W-2:0], 1'b1};
            end else begin
               rp_ff[k] <= rp_try;
               qp_ff[k] <= {qpin[NUM_W-2:0], 1'b0};
            end
            if (rq_try >= {1'b0, dn}) begin
               rq_ff[k] <= rq_try - {1'b0, dn};
               qq_ff[k] <= {qqin[NUM_W-2:0], 1'b1};
            end else begin
               rq_ff[k] <= rq_try;
               qq_ff[k] <= {qqin[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quot_p    = qp_ff[NUM_W-1];
   assign quot_q    = qq_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];
endmodule

### rtl/qrs_checker.sv
// Port-level checks on the result channel of the root solver.
// Depends on qrs_pkg; bound to the top level's result interface below.
module qrs_checker import qrs_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input root_kind_type            rsp_root_kind,
   input logic signed [ROOT_W-1:0] rsp_first_real,
   input logic signed [ROOT_W-1:0] rsp_first_imag,
   input logic signed [ROOT_W-1:0] rsp_second_real,
   input logic signed [ROOT_W-1:0] rsp_second_imag
);
   // a stalled transfer holds its valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // nothing leaves straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // no root means every part is zero
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_NONE |->
      rsp_first_real == '0 && rsp_second_real == '0 &&
      rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("no-root result with nonzero parts");

   // real and linear roots carry no imaginary part
   a_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_REAL ||
                    rsp_root_kind == KIND_LINEAR) |->
      rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("imaginary part on a real root");

   // a complex pair shares its real part
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_COMPLEX |->
      rsp_first_real == rsp_second_real)
      else $error("complex pair with differing real parts");
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_root_kind   (rsp_chan.root_kind),
   .rsp_first_real  (rsp_chan.first_real),
   .rsp_first_imag  (rsp_chan.first_imag),
   .rsp_second_real (rsp_chan.second_real),
   .rsp_second_imag (rsp_chan.second_imag)
);
